FILE: rtl/rpv_pkg.sv
// Package: limits, character codes and path state type for the relative path validator.
package rpv_pkg;

  localparam int MAX_PATH_CHARS = 128;
  localparam int MAX_DEPTH      = 8;

  localparam int CH_W    = 8;
  localparam int LEN_W   = $clog2(MAX_PATH_CHARS + 2);
  localparam int DEPTH_W = $clog2(MAX_DEPTH + 2);
  localparam int SEG_W   = 2;

  localparam logic [LEN_W-1:0]   LEN_MAX   = LEN_W'(MAX_PATH_CHARS);
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_DEPTH);
  localparam logic [SEG_W-1:0]   SEG_SAT   = 2'd3;

  localparam logic [CH_W-1:0] CH_CTRL_LIMIT = 8'h20;
  localparam logic [CH_W-1:0] CH_BACKSLASH  = 8'h5C;
  localparam logic [CH_W-1:0] CH_COLON      = 8'h3A;
  localparam logic [CH_W-1:0] CH_SLASH      = 8'h2F;
  localparam logic [CH_W-1:0] CH_DOT        = 8'h2E;

  typedef struct packed {
    logic [LEN_W-1:0]   path_length;
    logic [SEG_W-1:0]   segment_length;
    logic               segment_all_dots;
    logic [DEPTH_W-1:0] segment_count;
    logic               path_invalid;
  } path_state_t;

  localparam path_state_t STATE_CLEAR = '{
    path_length:      '0,
    segment_length:   '0,
    segment_all_dots: 1'b1,
    segment_count:    DEPTH_W'(1),
    path_invalid:     1'b0
  };

endpackage

FILE: rtl/rpv_in_if.sv
// Interface: path byte channel (valid/ready with byte, last and no_char).
interface rpv_in_if;
  logic                     valid;
  logic                     ready;
  logic [rpv_pkg::CH_W-1:0] ch;
  logic                     last;
  logic                     no_char;

  modport source (output valid, ch, last, no_char, input ready);
  modport sink   (input valid, ch, last, no_char, output ready);
endinterface

FILE: rtl/rpv_out_if.sv
// Interface: verdict channel (valid/ready with path_ok).
interface rpv_out_if;
  logic valid;
  logic ready;
  logic path_ok;

  modport source (output valid, path_ok, input ready);
  modport sink   (input valid, path_ok, output ready);
endinterface

FILE: rtl/relative_path_validator.sv
// Top level: relative path validator, byte stream in, one verdict per path out.
//
//   channel  | role | payload                 | beat
//   ---------+------+-------------------------+-------------------------------
//   chars    | sink | ch[7:0], last, no_char  | one path byte or an end marker
//   verdict  | src  | path_ok                 | one per beat with last = 1
//
// One beat per cycle sustained. A beat is registered at the input, then the
// path state and the verdict register update when that beat advances, so a
// verdict passes through the input register and then the verdict register.
// A full verdict register that is not taken holds a final beat in the input
// register, and the input with it; other beats are never held. Synchronous
// reset clears the valid flags and the path state.
module relative_path_validator (
  input logic  clk,
  input logic  rst,
  rpv_in_if.sink    chars,
  rpv_out_if.source verdict
);
  import rpv_pkg::*;

  logic            in_valid;
  logic [CH_W-1:0] ch_q;
  logic            last_q;
  logic            no_char_q;

  path_state_t state;
  path_state_t state_next;
  logic        ok_next;
  logic        advance;

  logic out_valid;
  logic out_ok;

  rpv_step u_step (
    .state      (state),
    .ch         (ch_q),
    .last       (last_q),
    .no_char    (no_char_q),
    .state_next (state_next),
    .path_ok    (ok_next)
  );

  assign advance     = in_valid && (!last_q || !out_valid || verdict.ready);
  assign chars.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (chars.ready) begin
      in_valid <= chars.valid;
    end
    if (chars.ready && chars.valid) begin
      ch_q      <= chars.ch;
      last_q    <= chars.last;
      no_char_q <= chars.no_char;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_CLEAR;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && last_q) begin
      out_valid <= 1'b1;
    end else if (verdict.ready) begin
      out_valid <= 1'b0;
    end
    if (advance && last_q) begin
      out_ok <= ok_next;
    end
  end

  assign verdict.valid   = out_valid;
  assign verdict.path_ok = out_ok;

endmodule

FILE: rtl/rpv_step.sv
// Per-byte update of the path state and the verdict on the final beat.
module rpv_step (
  input  rpv_pkg::path_state_t   state,
  input  logic [rpv_pkg::CH_W-1:0] ch,
  input  logic                   last,
  input  logic                   no_char,
  output rpv_pkg::path_state_t   state_next,
  output logic                   path_ok
);
  import rpv_pkg::*;

  path_state_t s;
  logic        bad_seg;
  logic        bad_end;

  always_comb begin
    s       = state;
    bad_seg = 1'b0;
    bad_end = 1'b0;

    if (!no_char) begin
      if (s.path_length <= LEN_MAX) begin
        s.path_length = s.path_length + LEN_W'(1);
      end
      if (s.path_length > LEN_MAX) begin
        s.path_invalid = 1'b1;
      end

      if (ch == CH_SLASH) begin
        // closing segment: empty, "." or ".." are rejected
        bad_seg = (s.segment_length == '0) ||
                  (s.segment_all_dots &&
                   (s.segment_length == 2'd1 || s.segment_length == 2'd2));
        if (bad_seg) begin
          s.path_invalid = 1'b1;
        end
        if (s.segment_count <= DEPTH_MAX) begin
          s.segment_count = s.segment_count + DEPTH_W'(1);
        end
        if (s.segment_count > DEPTH_MAX) begin
          s.path_invalid = 1'b1;
        end
        s.segment_length   = '0;
        s.segment_all_dots = 1'b1;
      end else begin
        if (ch < CH_CTRL_LIMIT || ch == CH_BACKSLASH || ch == CH_COLON) begin
          s.path_invalid = 1'b1;
        end
        if (s.segment_length != SEG_SAT) begin
          s.segment_length = s.segment_length + SEG_W'(1);
        end
        if (ch != CH_DOT) begin
          s.segment_all_dots = 1'b0;
        end
      end
    end

    // final segment check and empty path
    bad_end = (s.segment_length == '0) ||
              (s.segment_all_dots &&
               (s.segment_length == 2'd1 || s.segment_length == 2'd2)) ||
              (s.path_length == '0);
    path_ok = !(s.path_invalid || bad_end);

    state_next = last ? STATE_CLEAR : s;
  end

endmodule

FILE: verif/relative_path_validator_tb.sv
// Testbench: random and directed path streams checked against a built-in path rule predictor.
module relative_path_validator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rpv_pkg::*;

  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            last;
    logic            no_char;
    logic            hold;     // wait for all verdicts before presenting this beat
  } path_beat_t;

  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned TARGET_BYTES = 1200;

  logic clk;
  logic rst;

  rpv_in_if  chars_if ();
  rpv_out_if verdict_if ();

  relative_path_validator DUT (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars_if),
    .verdict (verdict_if)
  );

  path_beat_t  beats_pending[$];
  logic        verdicts_due[$];
  path_state_t walk;
  path_beat_t  cur_beat;
  int unsigned cyc;
  int unsigned quiet_cycles;
  int unsigned errors;
  int unsigned byte_beats;
  logic        steady;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // both sides run without gaps in the steady window of the cycle counter
  assign steady = (cyc % 3000) >= 2300;

  function automatic logic segment_bad(path_state_t s);
    return (s.segment_length == '0) ||
           (s.segment_all_dots && (s.segment_length == 2'd1 || s.segment_length == 2'd2));
  endfunction

  // Updates the path state with one beat and queues the verdict on a final beat.
  task automatic judge_beat(path_beat_t b);
    if (!b.no_char) begin
      if (walk.path_length <= LEN_MAX) walk.path_length = walk.path_length + LEN_W'(1);
      if (walk.path_length > LEN_MAX) walk.path_invalid = 1'b1;
      if (b.ch == CH_SLASH) begin
        if (segment_bad(walk)) walk.path_invalid = 1'b1;
        if (walk.segment_count <= DEPTH_MAX)
          walk.segment_count = walk.segment_count + DEPTH_W'(1);
        if (walk.segment_count > DEPTH_MAX) walk.path_invalid = 1'b1;
        walk.segment_length   = '0;
        walk.segment_all_dots = 1'b1;
      end else begin
        if (b.ch < CH_CTRL_LIMIT || b.ch == CH_BACKSLASH || b.ch == CH_COLON)
          walk.path_invalid = 1'b1;
        if (walk.segment_length < SEG_SAT)
          walk.segment_length = walk.segment_length + SEG_W'(1);
        if (b.ch != CH_DOT) walk.segment_all_dots = 1'b0;
      end
    end
    if (b.last) begin
      if (segment_bad(walk)) walk.path_invalid = 1'b1;
      if (walk.path_length == '0) walk.path_invalid = 1'b1;
      verdicts_due.push_back(!walk.path_invalid);
      walk = STATE_CLEAR;
    end
  endtask

  function automatic logic [CH_W-1:0] legal_byte();
    logic [CH_W-1:0] c;
    if ($urandom_range(7) == 0) return CH_DOT;
    do c = CH_W'($urandom_range(32, 255));
    while (c == CH_SLASH || c == CH_BACKSLASH || c == CH_COLON);
    return c;
  endfunction

  // Queues one path; byte-less filler beats are sprinkled in at random.
  task automatic send_path(logic [CH_W-1:0] pb[$], logic end_empty, logic hold);
    path_beat_t b;
    logic       first;
    first = 1'b1;
    foreach (pb[i]) begin
      if ($urandom_range(19) == 0) begin
        b = '{ch: CH_W'($urandom_range(255)), last: 1'b0, no_char: 1'b1, hold: hold & first};
        beats_pending.push_back(b);
        first = 1'b0;
      end
      b = '{ch: pb[i], last: (i == pb.size() - 1) && !end_empty, no_char: 1'b0,
            hold: hold & first};
      beats_pending.push_back(b);
      first = 1'b0;
      byte_beats++;
    end
    if (end_empty || pb.size() == 0) begin
      b = '{ch: CH_W'($urandom_range(255)), last: 1'b1, no_char: 1'b1, hold: hold & first};
      beats_pending.push_back(b);
    end
  endtask

  task automatic send_text(string s, logic end_empty = 1'b0, logic hold = 1'b0);
    logic [CH_W-1:0] pb[$];
    for (int i = 0; i < s.len(); i++) pb.push_back(s[i]);
    send_path(pb, end_empty, hold);
  endtask

  task automatic send_run(int n, int slash_every, logic hold = 1'b0);
    logic [CH_W-1:0] pb[$];
    for (int i = 0; i < n; i++)
      pb.push_back((slash_every > 0 && i % slash_every == slash_every - 1) ? CH_SLASH : 8'h61);
    send_path(pb, 1'b0, hold);
  endtask

  task automatic add_random_path();
    logic [CH_W-1:0] pb[$];
    int              kind;
    int              nseg;
    int              seglen;
    int              n;
    kind = $urandom_range(99);
    if (kind < 75) begin
      nseg = ($urandom_range(9) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 8);
      for (int s = 0; s < nseg; s++) begin
        if (s > 0) pb.push_back(CH_SLASH);
        if ($urandom_range(19) == 0) begin
          repeat ($urandom_range(1, 2)) pb.push_back(CH_DOT);
        end else begin
          seglen = ($urandom_range(29) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
          repeat (seglen) pb.push_back(legal_byte());
        end
      end
      // occasionally break an otherwise good path
      if ($urandom_range(9) == 0)
        pb[$urandom_range(pb.size() - 1)] = CH_W'($urandom_range(255));
    end else if (kind < 85) begin
      n = $urandom_range(120, 135);
      for (int i = 0; i < n; i++)
        pb.push_back((i % 25 == 24) ? CH_SLASH : legal_byte());
    end else begin
      n = $urandom_range(0, 12);
      repeat (n) begin
        case ($urandom_range(7))
          0:       pb.push_back(CH_SLASH);
          1:       pb.push_back(CH_DOT);
          2:       pb.push_back(CH_BACKSLASH);
          3:       pb.push_back(CH_COLON);
          default: pb.push_back(CH_W'($urandom_range(255)));
        endcase
      end
    end
    send_path(pb, $urandom_range(9) == 0, $urandom_range(14) == 0);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      chars_if.valid <= 1'b0;
    end else begin
      if (chars_if.valid && chars_if.ready) judge_beat(cur_beat);
      if (!chars_if.valid || chars_if.ready) begin
        if (beats_pending.size() == 0 || (!steady && $urandom_range(99) < 35) ||
            (beats_pending[0].hold && verdicts_due.size() != 0)) begin
          chars_if.valid <= 1'b0;
        end else begin
          cur_beat = beats_pending.pop_front();
          chars_if.valid   <= 1'b1;
          chars_if.ch      <= cur_beat.ch;
          chars_if.last    <= cur_beat.last;
          chars_if.no_char <= cur_beat.no_char;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    logic want;
    if (rst) begin
      verdict_if.ready <= 1'b0;
    end else begin
      verdict_if.ready <= steady || ($urandom_range(99) >= 35);
      if (verdict_if.valid && verdict_if.ready) begin
        if (verdicts_due.size() == 0) begin
          $error("path_ok: no verdict expected, actual %0b", verdict_if.path_ok);
          errors++;
        end else begin
          want = verdicts_due.pop_front();
          if (verdict_if.path_ok !== want) begin
            $error("path_ok: expected %0b, actual %0b", want, verdict_if.path_ok);
            errors++;
          end
        end
      end
    end
  end

  // watchdog on beats of either channel
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if ((chars_if.valid && chars_if.ready) || (verdict_if.valid && verdict_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    logic [CH_W-1:0] pb[$];
    rst                = 1'b1;
    cyc                = 0;
    quiet_cycles       = 0;
    errors             = 0;
    byte_beats         = 0;
    walk               = STATE_CLEAR;
    chars_if.valid     = 1'b0;
    chars_if.ch        = '0;
    chars_if.last      = 1'b0;
    chars_if.no_char   = 1'b0;
    verdict_if.ready   = 1'b0;

    send_text("", 1'b1);             // empty path
    send_text("a");
    send_text("ab/cd/ef");
    send_text("/a");
    send_text("a/");
    send_text("a//b");
    send_text(".");
    send_text("..");
    send_text("a/./b");
    send_text("x/..");
    send_text("...");
    send_text(".a/b.");
    send_text("a\\b");
    send_text("c:d");
    send_text(" ~");
    send_text("ab", 1'b1);           // byte-less final beat ends the path
    pb = '{8'h00};
    send_path(pb, 1'b0, 1'b0);
    pb = '{8'h61, 8'h1F};
    send_path(pb, 1'b0, 1'b0);
    pb = '{8'hFF, 8'h80};
    send_path(pb, 1'b0, 1'b0);
    send_text("a/b/c/d/e/f/g/h");
    send_text("a/b/c/d/e/f/g/h/i");
    send_run(40, 2);                 // twenty slashes, depth count saturates
    send_run(128, 0);
    send_run(129, 0, 1'b1);
    send_run(300, 0);                // length count saturates
    while (byte_beats < TARGET_BYTES) add_random_path();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (beats_pending.size() != 0 || chars_if.valid || verdicts_due.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0 && verdicts_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
